[hw/rtl/nrpl_pkg.sv]
package nrpl_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int SLOT_W    = 4;
  localparam int DIST_W    = 33;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic [14:0]        width;
    logic [14:0]        height;
  } rect_t;

  typedef struct packed {
    logic               op;
    logic [SLOT_W-1:0]  slot;
    logic signed [15:0] rect_left;
    logic signed [15:0] rect_top;
    logic [14:0]        rect_width;
    logic [14:0]        rect_height;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
  } req_t;

  typedef struct packed {
    logic               found;
    logic [SLOT_W-1:0]  best_slot;
    logic [DIST_W-1:0]  distance_sq;
    logic signed [15:0] hit_left;
    logic signed [15:0] hit_top;
    logic [14:0]        hit_width;
    logic [14:0]        hit_height;
  } rsp_t;

  // Travels alongside each slot through the distance pipeline
  typedef struct packed {
    logic             valid;
    logic             last;
    logic [IDX_W-1:0] idx;
  } tag_t;

  typedef struct packed {
    tag_t              tag;
    rect_t             rect;
    logic [DIST_W-1:0] dist_sq;
  } dist_res_t;

endpackage

[hw/rtl/nrpl_req_if.sv]
interface nrpl_req_if import nrpl_pkg::*; ();
  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[hw/rtl/nrpl_rsp_if.sv]
interface nrpl_rsp_if import nrpl_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[hw/rtl/nrpl_table.sv]
module nrpl_table import nrpl_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [IDX_W-1:0] wr_idx_i,
  input  rect_t            wr_rect_i,
  input  logic [IDX_W-1:0] rd_idx_i,
  output rect_t            rd_rect_o
);

  rect_t table_q [NUM_SLOTS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        table_q[i] <= '0;
      end
    end else if (wr_en_i) begin
      // an empty rectangle is held as all zero
      if (wr_rect_i.width == '0 || wr_rect_i.height == '0) begin
        table_q[wr_idx_i] <= '0;
      end else begin
        table_q[wr_idx_i] <= wr_rect_i;
      end
    end
  end

  assign rd_rect_o = table_q[rd_idx_i];

endmodule

[hw/rtl/nrpl_dist_unit.sv]
module nrpl_dist_unit import nrpl_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tag_t               tag_i,
  input  rect_t              rect_i,
  input  logic signed [15:0] point_x_i,
  input  logic signed [15:0] point_y_i,
  output dist_res_t          res_o
);

  function automatic logic [15:0] axis_gap(logic signed [15:0] p, logic signed [15:0] lo,
                                           logic [14:0] len);
    logic signed [17:0] p_x;
    logic signed [17:0] lo_x;
    logic signed [17:0] end_x;
    logic signed [17:0] d;
    p_x   = 18'(p);
    lo_x  = 18'(lo);
    end_x = lo_x + signed'({3'b000, len});
    d     = '0;
    if (p_x < lo_x) begin
      d = lo_x - p_x;
    end else if (p_x >= end_x) begin
      d = p_x - end_x + 18'sd1;
    end
    return d[15:0];
  endfunction

  tag_t  s1_tag_q, s2_tag_q, s3_tag_q;
  rect_t s1_rect_q, s2_rect_q, s3_rect_q;
  logic [15:0] dx_q, dy_q;
  logic [31:0] sqx_q, sqy_q;
  logic [DIST_W-1:0] dist_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_tag_q <= '0;
      s2_tag_q <= '0;
      s3_tag_q <= '0;
    end else begin
      s1_tag_q <= tag_i;
      s2_tag_q <= s1_tag_q;
      s3_tag_q <= s2_tag_q;
    end
  end

  always_ff @(posedge clk_i) begin
    // gaps on both axes
    s1_rect_q <= rect_i;
    dx_q      <= axis_gap(point_x_i, rect_i.left, rect_i.width);
    dy_q      <= axis_gap(point_y_i, rect_i.top, rect_i.height);
    // squares
    s2_rect_q <= s1_rect_q;
    sqx_q     <= dx_q * dx_q;
    sqy_q     <= dy_q * dy_q;
    // sum
    s3_rect_q <= s2_rect_q;
    dist_q    <= {1'b0, sqx_q} + {1'b0, sqy_q};
  end

  assign res_o.tag     = s3_tag_q;
  assign res_o.rect    = s3_rect_q;
  assign res_o.dist_sq = dist_q;

endmodule

[hw/rtl/nearest_rect_point_lookup.sv]
// Channel  Dir  Beat  Carries
// req_i    in   req_t write rectangle into a slot, or query a point
// rsp_o    out  rsp_t nearest non-empty rectangle, one beat per query
//
// A query feeds one distance pipeline (gap, square, sum) one slot a cycle from the
// slot counter, and its results are compared against the running best.
// req_i is ready only while idle; a result waiting on rsp_o does not block writes.
// Reset clears the whole table at once, every slot empty; no sweep is needed.
module nearest_rect_point_lookup import nrpl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  nrpl_req_if.sink   req_i,
  nrpl_rsp_if.source rsp_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic signed [15:0] px_q, py_q;
  logic               found_q, found_d;
  logic [IDX_W-1:0]   best_idx_q, best_idx_d;
  logic [DIST_W-1:0]  best_dist_q, best_dist_d;
  rect_t              best_rect_q, best_rect_d;
  logic               out_valid_q, out_valid_d;
  rsp_t               rsp_q, rsp_d;

  logic      accept;
  logic      wr_en;
  rect_t     wr_rect;
  rect_t     rd_rect;
  tag_t      issue;
  dist_res_t res;
  logic      res_live;
  logic      out_load;

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;

  assign wr_en = accept && (req_i.payload.op == OP_WRITE) &&
                 (32'(req_i.payload.slot) < NUM_SLOTS);
  assign wr_rect.left   = req_i.payload.rect_left;
  assign wr_rect.top    = req_i.payload.rect_top;
  assign wr_rect.width  = req_i.payload.rect_width;
  assign wr_rect.height = req_i.payload.rect_height;

  nrpl_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_idx_i  (IDX_W'(req_i.payload.slot)),
    .wr_rect_i (wr_rect),
    .rd_idx_i  (idx_q),
    .rd_rect_o (rd_rect)
  );

  assign issue.valid = (state_q == ST_RUN);
  assign issue.last  = (idx_q == LAST_IDX);
  assign issue.idx   = idx_q;

  nrpl_dist_unit u_dist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tag_i     (issue),
    .rect_i    (rd_rect),
    .point_x_i (px_q),
    .point_y_i (py_q),
    .res_o     (res)
  );

  assign res_live = res.tag.valid && (res.rect.width != '0) && (res.rect.height != '0);
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || rsp_o.ready);

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    found_d     = found_q;
    best_idx_d  = best_idx_q;
    best_dist_d = best_dist_q;
    best_rect_d = best_rect_q;
    out_valid_d = out_valid_q;
    rsp_d       = rsp_q;

    if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    // strict less-than keeps the lowest slot on ties
    if (res_live && (!found_q || res.dist_sq < best_dist_q)) begin
      found_d     = 1'b1;
      best_idx_d  = res.tag.idx;
      best_dist_d = res.dist_sq;
      best_rect_d = res.rect;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept && req_i.payload.op == OP_QUERY) begin
          idx_d   = '0;
          found_d = 1'b0;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (issue.last) begin
          state_d = ST_DRAIN;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (res.tag.valid && res.tag.last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          if (found_q) begin
            rsp_d.found       = 1'b1;
            rsp_d.best_slot   = SLOT_W'(best_idx_q);
            rsp_d.distance_sq = best_dist_q;
            rsp_d.hit_left    = best_rect_q.left;
            rsp_d.hit_top     = best_rect_q.top;
            rsp_d.hit_width   = best_rect_q.width;
            rsp_d.hit_height  = best_rect_q.height;
          end else begin
            rsp_d = '0;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q <= req_i.payload.point_x;
      py_q <= req_i.payload.point_y;
    end
    best_idx_q  <= best_idx_d;
    best_dist_q <= best_dist_d;
    best_rect_q <= best_rect_d;
    rsp_q       <= rsp_d;
  end

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = rsp_q;

endmodule
